FILE: rtl/core/kvtcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kvtcp_pkg;
    localparam int LINE_CAP = 64;
    localparam int AW = 6;
    localparam int LW = 7;

    typedef enum logic [1:0] {
        KIND_KEY    = 2'd0,
        KIND_CLOSE  = 2'd1,
        KIND_STORED = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIMPLE,
        ST_RD0,
        ST_CHK,
        ST_GSP,
        ST_GKEY,
        ST_SSCAN,
        ST_EMIT,
        ST_EMIT_WAIT
    } state_t;

    localparam logic [0:0] REG_PARSE_MODE = 1'd0;
    localparam logic [0:0] REG_VALUE_SIZE = 1'd1;
    localparam logic [31:0] SIZE_SAT = 32'd2147483647;

    function automatic logic is_ws(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/kvtcp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module kvtcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/keyvalue_text_command_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// byte-serial memcached-style text front end. each request carries one received
// byte; bytes are kept in a 64-entry line ram until cr lf. a line end walks the
// stored line one byte a cycle through a single ram read port under a small
// sequencer; the key walk of a get waits while a reply is not taken. a get line
// checks its header, searches for the space, then sends one reply per key byte
// and one for the close; a set line scans its fields; any other line, or a get
// or set line that fails, gets an error reply. in simple mode every line gets
// the key "key" and a close. a stored reply appears the cycle after the last
// swallowed byte. s_axis_tready is low while a line is processed or a reply is
// waiting. the set size is accumulated with one multiply-by-ten adder,
// saturating at 2147483647; a set line then swallows size+2 bytes.
module keyvalue_text_command_parser
    import kvtcp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // reply_kind, key_byte, value_length, pad
    output logic             m_axis_tlast,   // last
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [20:0] cfg_data
);
    state_t state_reg, state_next;
    logic        mode_reg;
    logic [20:0] vsize_reg;
    logic [LW-1:0] len_reg, len_next;      // bytes held
    logic [LW-1:0] llen_reg, llen_next;    // length of the line being parsed
    logic [LW-1:0] idx_reg, idx_next;      // walk pointer
    logic        prev_cr_reg, prev_cr_next;
    logic        skip_reg, skip_next;
    logic [31:0] cnt_reg, cnt_next;
    // output holding register
    logic        ov_reg, ov_next;
    kind_t       ok_reg, ok_next;
    logic [7:0]  ob_reg, ob_next;
    logic        ol_reg, ol_next;
    // simple-mode counter and get/set flags
    logic [1:0]  sc_reg, sc_next;
    logic        isget_reg, isget_next, isset_reg, isset_next;
    // set scan state
    logic [2:0]  fld_reg, fld_next;        // field number 0..4, 5 once all are done
    logic        intok_reg, intok_next;
    logic        sgn_reg, sgn_next;        // sign seen at field start
    logic        dig_reg, dig_next;        // any digit in field
    logic        neg_reg, neg_next;
    logic [31:0] acc_reg, acc_next;
    logic        bad_reg, bad_next;        // int field ended badly
    kind_t       ek_reg, ek_next;          // pending single reply

    logic [7:0]  rd;
    logic [AW-1:0] raddr;
    logic        we;
    logic        s_fire, out_free;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free = !ov_reg || m_axis_tready;
    assign we       = s_fire && !(!mode_reg && skip_reg);

    kvtcp_ram #(.WIDTH(8), .DEPTH(LINE_CAP)) u_line (
        .aclk(aclk), .we(we), .waddr(len_reg[AW-1:0]), .wdata(s_axis_tdata),
        .raddr(raddr), .rdata(rd)
    );

    assign s_axis_tready = state_reg == ST_IDLE && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tlast  = ol_reg;
    assign m_axis_tdata  = {1'b0, (ok_reg == KIND_CLOSE) ? vsize_reg : 21'd0, ob_reg, ok_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            vsize_reg <= 21'd2;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PARSE_MODE: mode_reg  <= cfg_data[0];
                REG_VALUE_SIZE: vsize_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg <= '0; prev_cr_reg <= 1'b0; skip_reg <= 1'b0; cnt_reg <= '0;
            ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg <= len_next; prev_cr_reg <= prev_cr_next;
            skip_reg <= skip_next; cnt_reg <= cnt_next; ov_reg <= ov_next;
        end
        llen_reg <= llen_next; idx_reg <= idx_next; ok_reg <= ok_next;
        ob_reg <= ob_next; ol_reg <= ol_next; sc_reg <= sc_next;
        isget_reg <= isget_next; isset_reg <= isset_next; fld_reg <= fld_next;
        intok_reg <= intok_next; sgn_reg <= sgn_next; dig_reg <= dig_next;
        neg_reg <= neg_next; acc_reg <= acc_next; bad_reg <= bad_next;
        ek_reg <= ek_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire && !(!mode_reg && skip_reg) && s_axis_tdata == 8'd10
                         && prev_cr_reg) begin
                state_next = mode_reg ? ST_SIMPLE : ST_RD0;
            end
            ST_SIMPLE: if (out_free && sc_reg == 2'd3) state_next = ST_IDLE;
            ST_RD0:  state_next = ST_CHK;
            ST_CHK:  if (idx_reg == 7'd3 || !(isget_next || isset_next)) begin
                state_next = (llen_reg >= 7'd3 && isget_next) ? ST_GSP :
                             (llen_reg >= 7'd3 && isset_next) ? ST_SSCAN : ST_EMIT;
            end
            ST_GSP: if (idx_reg >= llen_reg || rd == 8'd32) state_next =
                (idx_reg + 7'd1 >= llen_reg) ? ST_EMIT : ST_GKEY;
            ST_GKEY: if (out_free && (idx_reg >= llen_reg || rd == 8'd32))
                state_next = ST_IDLE;
            ST_SSCAN: if (bad_next || fld_next == 3'd5 || idx_reg >= llen_reg) begin
                state_next = (ek_next == KIND_ERROR) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic [7:0]  ch;
        logic [35:0] m10;
        logic [3:0]  d;
        len_next = len_reg; prev_cr_next = prev_cr_reg; skip_next = skip_reg;
        cnt_next = cnt_reg; llen_next = llen_reg; idx_next = idx_reg;
        ov_next = ov_reg && !m_axis_tready; ok_next = ok_reg; ob_next = ob_reg;
        ol_next = ol_reg; sc_next = sc_reg; isget_next = isget_reg;
        isset_next = isset_reg; fld_next = fld_reg; intok_next = intok_reg;
        sgn_next = sgn_reg; dig_next = dig_reg; neg_next = neg_reg;
        acc_next = acc_reg; bad_next = bad_reg; ek_next = ek_reg;
        raddr = idx_reg[AW-1:0];
        ch = rd;
        d = rd[3:0];
        m10 = {4'd0, acc_reg} * 36'd10 + {32'd0, d};
        unique case (state_reg)
            ST_IDLE: begin
                raddr = '0;
                if (s_fire) begin
                    if (!mode_reg && skip_reg) begin
                        if (cnt_reg <= 32'd1) begin
                            cnt_next = '0; skip_next = 1'b0;
                            ov_next = 1'b1; ok_next = KIND_STORED; ob_next = '0;
                            ol_next = 1'b1;
                        end else begin
                            cnt_next = cnt_reg - 32'd1;
                        end
                    end else if (s_axis_tdata == 8'd10 && prev_cr_reg) begin
                        len_next = '0; prev_cr_next = 1'b0;
                        llen_next = len_reg - 7'd1;
                        idx_next = '0; sc_next = '0;
                        isget_next = 1'b1; isset_next = 1'b1;
                    end else if (len_reg + 7'd1 >= 7'(LINE_CAP - 1)) begin
                        len_next = '0; prev_cr_next = 1'b0;
                    end else begin
                        len_next = len_reg + 7'd1;
                        prev_cr_next = s_axis_tdata == 8'd13;
                    end
                end
            end
            ST_SIMPLE: if (out_free) begin
                ov_next = 1'b1; ob_next = '0; ol_next = 1'b0; ok_next = KIND_KEY;
                unique case (sc_reg)
                    2'd0: ob_next = 8'h6b;
                    2'd1: ob_next = 8'h65;
                    2'd2: ob_next = 8'h79;
                    default: begin ok_next = KIND_CLOSE; ol_next = 1'b1; end
                endcase
                sc_next = sc_reg + 2'd1;
            end
            ST_RD0: begin
                raddr = 6'd0; idx_next = 7'd1;
            end
            ST_CHK: begin
                // rd holds byte idx-1
                unique case (idx_reg)
                    7'd1: begin
                        isget_next = ch == 8'h67 || ch == 8'h47;
                        isset_next = ch == 8'h73 || ch == 8'h53;
                    end
                    7'd2: begin
                        isget_next = isget_reg && (ch == 8'h65 || ch == 8'h45);
                        isset_next = isset_reg && (ch == 8'h65 || ch == 8'h45);
                    end
                    default: begin
                        isget_next = isget_reg && (ch == 8'h74 || ch == 8'h54);
                        isset_next = isset_reg && (ch == 8'h74 || ch == 8'h54);
                    end
                endcase
                idx_next = idx_reg + 7'd1;
                ek_next = KIND_ERROR;
                if (idx_reg == 7'd3 || !(isget_next || isset_next)) begin
                    raddr = '0; idx_next = '0;
                    fld_next = '0; intok_next = 1'b0; bad_next = 1'b0;
                    sgn_next = 1'b0; dig_next = 1'b0; neg_next = 1'b0; acc_next = '0;
                end
            end
            ST_GSP: begin
                // rd holds byte idx
                if (idx_reg >= llen_reg || rd == 8'd32) begin
                    idx_next = idx_reg + 7'd1; raddr = 6'(idx_reg + 7'd1);
                end else begin
                    idx_next = idx_reg + 7'd1; raddr = 6'(idx_reg + 7'd1);
                end
            end
            ST_GKEY: begin
                raddr = idx_reg[AW-1:0];
                if (out_free) begin
                    ov_next = 1'b1;
                    if (idx_reg >= llen_reg || rd == 8'd32) begin
                        ok_next = KIND_CLOSE; ob_next = '0; ol_next = 1'b1;
                    end else begin
                        ok_next = KIND_KEY; ob_next = rd; ol_next = 1'b0;
                        idx_next = idx_reg + 7'd1; raddr = 6'(idx_reg + 7'd1);
                    end
                end
            end
            ST_SSCAN: begin
                // fields 0,1 tokens; 2..4 integers; rd holds byte idx
                if (idx_reg < llen_reg) begin
                    idx_next = idx_reg + 7'd1; raddr = 6'(idx_reg + 7'd1);
                    if (!intok_reg) begin
                        if (!is_ws(ch)) begin
                            intok_next = 1'b1;
                            if (fld_reg >= 3'd2) begin
                                acc_next = '0; neg_next = 1'b0; dig_next = 1'b0;
                                sgn_next = 1'b0;
                                if (ch == 8'h2b || ch == 8'h2d) begin
                                    sgn_next = 1'b1; neg_next = ch == 8'h2d;
                                end else if (is_digit(ch)) begin
                                    dig_next = 1'b1; acc_next = {28'd0, d};
                                end else begin
                                    bad_next = 1'b1;
                                end
                            end
                        end
                    end else if (fld_reg < 3'd2) begin
                        if (is_ws(ch)) begin
                            intok_next = 1'b0; fld_next = fld_reg + 3'd1;
                        end
                    end else if (is_digit(ch)) begin
                        dig_next = 1'b1;
                        acc_next = (m10 > {4'd0, SIZE_SAT}) ? SIZE_SAT : m10[31:0];
                    end else if (!dig_reg) begin
                        bad_next = 1'b1;
                    end else begin
                        intok_next = 1'b0; fld_next = fld_reg + 3'd1;
                        // a +/- terminator opens the next field; other non-space: bad
                        if (fld_reg != 3'd4 && !is_ws(ch)) begin
                            if (ch == 8'h2b || ch == 8'h2d) begin
                                intok_next = 1'b1; acc_next = '0; dig_next = 1'b0;
                                sgn_next = 1'b1; neg_next = ch == 8'h2d;
                            end else begin
                                bad_next = 1'b1;
                            end
                        end
                    end
                end else begin
                    // end of line closes an integer field with digits
                    if (intok_reg && fld_reg >= 3'd2 && dig_reg) fld_next = fld_reg + 3'd1;
                end
                if (fld_next == 3'd5 && !bad_next) begin
                    if (neg_next && acc_next != 32'd0) begin
                        ek_next = KIND_ERROR;
                    end else begin
                        ek_next = KIND_STORED;
                        skip_next = 1'b1; cnt_next = acc_next + 32'd2;
                    end
                end
            end
            ST_EMIT: if (out_free) begin
                ov_next = 1'b1; ok_next = KIND_ERROR; ob_next = '0; ol_next = 1'b1;
            end
            default: ;
        endcase
    end

    property p_ready_hold;
        @(posedge aclk) disable iff (!aresetn) m_axis_tvalid |-> !s_axis_tready;
    endproperty
    a_ready_hold: assert property (p_ready_hold) else $error("ready with reply pending");

    property p_len_cap;
        @(posedge aclk) disable iff (!aresetn) len_reg < 7'(LINE_CAP - 1);
    endproperty
    a_len_cap: assert property (p_len_cap) else $error("line length overflow");

    property p_out_data;
        @(posedge aclk) disable iff (!aresetn)
            (m_axis_tvalid && ok_reg != KIND_KEY) |-> ob_reg == 8'd0;
    endproperty
    a_out_data: assert property (p_out_data) else $error("key byte on non-key reply");
endmodule
`default_nettype wire
